// ===== src/assert_macros.svh =====
// Assertion helpers included by bsm_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, skipped while reset is held.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg
// Types and constants for the bank switch mapper with battery SRAM.
// ----------------------------------------------------------------------------
package bsm_pkg;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_16K     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRAM_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRAM_AMASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MASK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_MASK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOW    = 3'd7;
    localparam int CFG_DATA_W = 16;

    // address bits 15..13 of interest
    localparam logic [2:0] AREA_LOW  = 3'b010;   // 4000h-5FFFh
    localparam logic [2:0] AREA_BANK = 3'b011;   // 6000h-7FFFh, bank registers

    localparam int OFFSET_W   = 13;
    localparam int PAGE_W     = 9;
    localparam int BYTE_W     = 8;
    localparam int CPU_ADDR_W = 16;
    localparam int NUM_PAGES  = 4;
    localparam int PAGE_IDX_W = 2;

    localparam logic [CPU_ADDR_W-1:0] OFFSET_MASK = 16'h1FFF;
    localparam logic [CPU_ADDR_W-1:0] HALF_BIT    = 16'h2000;
    localparam logic [BYTE_W-1:0]     SRAM_FILL   = 8'hFF;
    localparam logic [PAGE_W-1:0]     ROM_MASK_RST = 9'h1FF;

    localparam int S_TDATA_W = 24;  // address, data
    localparam int M_TDATA_W = 32;  // read_data, rom_page, rom_offset, pad
    localparam int M_TUSER_W = 2;   // in_window, from_sram

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic clr_en;   // write fill pattern at the clear counter
        logic accept;   // latch incoming word
        logic exec;     // update mapper state, access SRAM
        logic load;     // capture result into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last; // clear counter at last entry
        logic out_busy; // output register full and not drained this cycle
    } ctrl_sts_t;

endpackage

// ===== src/bsm_ram.sv =====
// ----------------------------------------------------------------------------
// bsm_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsm_ctrl
// Sequencer: SRAM clear after reset, then accept / execute / load per word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  bsm_pkg::ctrl_sts_t sts,
    output bsm_pkg::ctrl_cmd_t cmd
);

    bsm_pkg::state_t state_reg, state_next;

    logic in_clear;
    logic in_idle;
    logic in_exec;
    logic in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsm_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            bsm_pkg::ST_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = bsm_pkg::ST_IDLE;
                end
            end
            bsm_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = bsm_pkg::ST_EXEC;
                end
            end
            bsm_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = bsm_pkg::ST_LOAD;
            end
            bsm_pkg::ST_LOAD: begin
                // wait here while the previous result is still held
                if (!sts.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = bsm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsm_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_clear = (state_reg == bsm_pkg::ST_CLEAR);
    assign in_idle  = (state_reg == bsm_pkg::ST_IDLE);
    assign in_exec  = (state_reg == bsm_pkg::ST_EXEC);
    assign in_load  = (state_reg == bsm_pkg::ST_LOAD);

    `ASSERT_RST(a_accept_to_exec, aclk, aresetn, (in_idle && s_tvalid) |=> in_exec, "no execute")
    `ASSERT_RST(a_clear_once, aclk, aresetn, !in_clear |=> !in_clear, "clear pass restarted")
    `ASSERT_RST(a_load_holds, aclk, aresetn, (in_load && sts.out_busy) |=> in_load, "result dropped")

endmodule

// ===== src/bsm_dp.sv =====
// ----------------------------------------------------------------------------
// bsm_dp
// Datapath: config registers, page mapping registers, SRAM and output word.
// ----------------------------------------------------------------------------
module bsm_dp #(
    parameter int SRAM_BYTES = 32768
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bsm_pkg::ctrl_cmd_t                    cmd,
    output bsm_pkg::ctrl_sts_t                    sts,
    input  logic                                  cfg_we,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic [bsm_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bsm_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [bsm_pkg::M_TUSER_W-1:0]         m_tuser
);

    localparam int AW = $clog2(SRAM_BYTES);

    // configuration
    logic                     bank_16k_reg;
    logic [8:0]               range_mask_reg;
    logic [8:0]               rom_mask_reg;
    logic                     sram_en_reg;
    logic [15:0]              sram_amask_reg;
    logic [7:0]               sel_mask_reg;
    logic [7:0]               prot_mask_reg;
    logic                     wlow_reg;

    // mapper state
    logic [8:0]               rom_bank_reg [bsm_pkg::NUM_PAGES];
    logic                     is_sram_reg  [bsm_pkg::NUM_PAGES];
    logic                     wr_ok_reg    [bsm_pkg::NUM_PAGES];
    logic [15:0]              base_reg     [bsm_pkg::NUM_PAGES];

    // latched word
    logic                     op_reg;
    logic [15:0]              addr_reg;
    logic [7:0]               data_reg;

    logic [AW-1:0]            clr_cnt_reg;

    logic                     out_valid_reg;
    logic [bsm_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [bsm_pkg::M_TUSER_W-1:0] out_user_reg;

    // decode
    logic                     inwin;
    logic [1:0]               pg;
    logic                     bank_wr;
    logic                     wide;
    logic                     bw_skip;
    logic [1:0]               bw_page;
    logic [1:0]               bw_pair;
    logic                     sel;
    logic [8:0]               sel_chk;
    logic [15:0]              shifted;
    logic [15:0]              base_lo;
    logic [15:0]              base_hi;
    logic                     wr_ok;
    logic [8:0]               rom_lo;
    logic [8:0]               rom_hi;
    logic                     data_wr;
    logic                     rd_sram;
    logic                     rd_rom;
    logic [15:0]              sram_idx;

    logic                     ram_we;
    logic                     ram_re;
    logic [AW-1:0]            ram_addr;
    logic [7:0]               ram_wdata;
    logic [7:0]               ram_rdata;

    logic [7:0]               res_rdata;
    logic [8:0]               res_page;
    logic [12:0]              res_offset;

    always_comb begin
        inwin   = (addr_reg[15:14] == 2'b01) || (addr_reg[15:14] == 2'b10);
        pg      = {~addr_reg[14], addr_reg[13]};
        bank_wr = (op_reg == bsm_pkg::OP_WRITE) && (addr_reg[15:13] == bsm_pkg::AREA_BANK);

        wide    = bank_16k_reg;
        // odd register halves are dead in 16 KB mode
        bw_skip = wide && addr_reg[11];
        bw_page = addr_reg[12:11];
        bw_pair = bw_page | {1'b0, wide};
        sel_chk = ({1'b0, data_reg ^ sel_mask_reg} << wide) & range_mask_reg;
        sel     = sram_en_reg && ((data_reg & sel_mask_reg) != 8'd0) && (sel_chk == 9'd0);
        shifted = wide ? {data_reg[1:0], 14'd0} : {data_reg[2:0], 13'd0};
        base_lo = shifted & sram_amask_reg;
        base_hi = (shifted | (wide ? bsm_pkg::HALF_BIT : 16'd0)) & sram_amask_reg;
        wr_ok   = ((data_reg & prot_mask_reg) == 8'd0);
        rom_lo  = (wide ? {data_reg, 1'b0} : {1'b0, data_reg}) & rom_mask_reg;
        rom_hi  = rom_lo | {8'd0, wide};

        data_wr = (op_reg == bsm_pkg::OP_WRITE) && !bank_wr && inwin && sram_en_reg
                  && ((addr_reg[15:13] != bsm_pkg::AREA_LOW) || wlow_reg)
                  && is_sram_reg[pg] && wr_ok_reg[pg];
        rd_sram = (op_reg == bsm_pkg::OP_READ) && inwin && sram_en_reg && is_sram_reg[pg];
        rd_rom  = (op_reg == bsm_pkg::OP_READ) && inwin && !rd_sram;

        sram_idx = base_reg[pg] | (addr_reg & sram_amask_reg & bsm_pkg::OFFSET_MASK);

        res_rdata  = rd_sram ? ram_rdata : 8'd0;
        res_page   = rd_rom ? rom_bank_reg[pg] : 9'd0;
        res_offset = rd_rom ? addr_reg[12:0] : 13'd0;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_16k_reg   <= 1'b0;
            range_mask_reg <= '0;
            rom_mask_reg   <= bsm_pkg::ROM_MASK_RST;
            sram_en_reg    <= 1'b0;
            sram_amask_reg <= '0;
            sel_mask_reg   <= '0;
            prot_mask_reg  <= '0;
            wlow_reg       <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                bsm_pkg::CFG_BANK_16K:     bank_16k_reg   <= cfg_wdata[0];
                bsm_pkg::CFG_RANGE_MASK:   range_mask_reg <= cfg_wdata[8:0];
                bsm_pkg::CFG_ROM_MASK:     rom_mask_reg   <= cfg_wdata[8:0];
                bsm_pkg::CFG_SRAM_ENABLE:  sram_en_reg    <= cfg_wdata[0];
                bsm_pkg::CFG_SRAM_AMASK:   sram_amask_reg <= cfg_wdata;
                bsm_pkg::CFG_SELECT_MASK:  sel_mask_reg   <= cfg_wdata[7:0];
                bsm_pkg::CFG_PROTECT_MASK: prot_mask_reg  <= cfg_wdata[7:0];
                bsm_pkg::CFG_WRITE_LOW:    wlow_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // page mapping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bsm_pkg::NUM_PAGES; i++) begin
                rom_bank_reg[i] <= '0;
                is_sram_reg[i]  <= 1'b0;
                wr_ok_reg[i]    <= 1'b1;
                base_reg[i]     <= '0;
            end
        end else if (cfg_we && cfg_addr == bsm_pkg::CFG_BANK_16K) begin
            // mode change reloads the ROM pages as 0, b, 0, b
            rom_bank_reg[0] <= '0;
            rom_bank_reg[1] <= {8'd0, cfg_wdata[0]};
            rom_bank_reg[2] <= '0;
            rom_bank_reg[3] <= {8'd0, cfg_wdata[0]};
        end else if (cmd.exec && bank_wr && !bw_skip) begin
            // the pair is a separate page only in 16 KB mode
            if (sram_en_reg) begin
                is_sram_reg[bw_page] <= sel;
                if (wide) begin
                    is_sram_reg[bw_pair] <= sel;
                end
            end
            if (sel) begin
                base_reg[bw_page]  <= base_lo;
                wr_ok_reg[bw_page] <= wr_ok;
                if (wide) begin
                    base_reg[bw_pair]  <= base_hi;
                    wr_ok_reg[bw_pair] <= wr_ok;
                end
            end else begin
                rom_bank_reg[bw_page] <= rom_lo;
                if (wide) begin
                    rom_bank_reg[bw_pair] <= rom_hi;
                end
            end
        end
    end

    // input word latch
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_tuser;
            addr_reg <= s_tdata[15:0];
            data_reg <= s_tdata[23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == {AW{1'b1}});
    assign sts.out_busy = out_valid_reg && !m_tready;

    assign ram_we    = cmd.clr_en || (cmd.exec && data_wr);
    assign ram_re    = cmd.exec && rd_sram;
    assign ram_addr  = cmd.clr_en ? clr_cnt_reg : sram_idx[AW-1:0];
    assign ram_wdata = cmd.clr_en ? bsm_pkg::SRAM_FILL : data_reg;

    bsm_ram #(
        .WIDTH (bsm_pkg::BYTE_W),
        .DEPTH (SRAM_BYTES)
    ) u_sram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_data_reg <= {2'b00, res_offset, res_page, res_rdata};
            out_user_reg <= {rd_sram, inwin};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== src/bank_switch_mapper_with_sram_unit.sv =====
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_sram_unit
// Cartridge bank mapper with battery SRAM for the 4000h-BFFFh window.
// ----------------------------------------------------------------------------
// Path: an accepted word is executed (with SRAM read), then loaded into the output register.
// Flow: words are taken one at a time, the controller walking idle, execute and load
//   around the single-port SRAM; a held result stalls load and blocks the next accept.
// Reset: synchronous, active low; config and page registers return to defaults,
//   then a clear pass fills the SRAM with FFh with s_tready low. Config writes
//   are taken during the pass.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_sram_unit #(
    parameter int SRAM_BYTES = 32768   // power of two, 512 to 65536
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bsm_pkg::S_TDATA_W-1:0]         s_tdata,   // address[15:0], data[23:16]
    input  logic                                  s_tuser,   // op
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bsm_pkg::M_TDATA_W-1:0]         m_tdata,   // read_data[7:0], rom_page[16:8],
                                                             // rom_offset[29:17], zero pad
    output logic [bsm_pkg::M_TUSER_W-1:0]         m_tuser    // in_window[0], from_sram[1]
);

    bsm_pkg::ctrl_cmd_t cmd;
    bsm_pkg::ctrl_sts_t sts;

    bsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsm_dp #(
        .SRAM_BYTES (SRAM_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the cartridge bank mapper with battery SRAM. A shadow copy of the
// mapper (page registers, SRAM image, config) predicts every result word;
// results are checked in order against the predictions. Directed accesses
// cover window edges, ROM banking, SRAM select/protect and 16 KB mode, then
// random traffic runs under several config settings, with and without back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD     = 12;
    localparam int SRAM_BYTES     = 32768;
    localparam int WATCHDOG_LIMIT = 100000;  // must outlast the SRAM clear pass after reset

    typedef struct packed {
        logic                         in_window;
        logic                         from_sram;
        logic [bsm_pkg::BYTE_W-1:0]   read_data;
        logic [bsm_pkg::PAGE_W-1:0]   rom_page;
        logic [bsm_pkg::OFFSET_W-1:0] rom_offset;
    } access_reply_t;

    typedef struct {
        logic        mode_16k;
        logic [8:0]  range_mask;
        logic [8:0]  rom_mask;
        logic        sram_on;
        logic [15:0] sram_amask;
        logic [7:0]  select_bit;
        logic [7:0]  protect_bit;
        logic        low_writes;
    } mapper_cfg_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [bsm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [bsm_pkg::S_TDATA_W-1:0]  s_tdata   = '0;   // address[15:0], data[23:16]
    logic                           s_tuser   = 1'b0; // op
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [bsm_pkg::M_TDATA_W-1:0]  m_tdata;  // read_data[7:0], rom_page[16:8], rom_offset[29:17]
    logic [bsm_pkg::M_TUSER_W-1:0]  m_tuser;  // in_window[0], from_sram[1]

    // shadow of the mapper
    mapper_cfg_t                cfg_shadow;
    logic [bsm_pkg::PAGE_W-1:0] page_rom   [bsm_pkg::NUM_PAGES];
    logic                       page_sram  [bsm_pkg::NUM_PAGES];
    logic                       page_wr    [bsm_pkg::NUM_PAGES];
    logic [15:0]                page_base  [bsm_pkg::NUM_PAGES];
    logic [bsm_pkg::BYTE_W-1:0] sram_image [SRAM_BYTES];

    access_reply_t expected_replies[$];
    int  error_count     = 0;
    int  words_checked   = 0;
    int  quiet_cycles    = 0;
    int  hold_request    = 0;
    bit  sender_gaps     = 1'b1;
    bit  receiver_stalls = 1'b1;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    bank_switch_mapper_with_sram_unit #(.SRAM_BYTES(SRAM_BYTES)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------
    function automatic void reload_rom_pages();
        page_rom[0] = '0;
        page_rom[1] = bsm_pkg::PAGE_W'(cfg_shadow.mode_16k);
        page_rom[2] = '0;
        page_rom[3] = bsm_pkg::PAGE_W'(cfg_shadow.mode_16k);
    endfunction

    function automatic void model_reset();
        cfg_shadow = '{1'b0, 9'h000, bsm_pkg::ROM_MASK_RST, 1'b0, 16'h0000, 8'h00, 8'h00,
                       1'b0};
        reload_rom_pages();
        for (int i = 0; i < bsm_pkg::NUM_PAGES; i++) begin
            page_sram[i] = 1'b0;
            page_wr[i]   = 1'b1;
            page_base[i] = '0;
        end
        for (int i = 0; i < SRAM_BYTES; i++) sram_image[i] = bsm_pkg::SRAM_FILL;
    endfunction

    function automatic void shadow_reg_write(input logic [bsm_pkg::CFG_IDX_W-1:0] idx,
                                             input logic [bsm_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            bsm_pkg::CFG_BANK_16K: begin
                cfg_shadow.mode_16k = value[0];
                reload_rom_pages();
            end
            bsm_pkg::CFG_RANGE_MASK:   cfg_shadow.range_mask  = value[8:0];
            bsm_pkg::CFG_ROM_MASK:     cfg_shadow.rom_mask    = value[8:0];
            bsm_pkg::CFG_SRAM_ENABLE:  cfg_shadow.sram_on     = value[0];
            bsm_pkg::CFG_SRAM_AMASK:   cfg_shadow.sram_amask  = value;
            bsm_pkg::CFG_SELECT_MASK:  cfg_shadow.select_bit  = value[7:0];
            bsm_pkg::CFG_PROTECT_MASK: cfg_shadow.protect_bit = value[7:0];
            bsm_pkg::CFG_WRITE_LOW:    cfg_shadow.low_writes  = value[0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned sram_slot(input logic [1:0] pg, input logic [15:0] addr);
        return (page_base[pg] | (addr & cfg_shadow.sram_amask & bsm_pkg::OFFSET_MASK))
               % SRAM_BYTES;
    endfunction

    // write to a bank register at 6000h-7FFFh
    function automatic void bank_select(input logic [15:0] addr, input logic [7:0] v);
        int unsigned wide, pg, pair, vv, rom;
        logic hit;
        wide = cfg_shadow.mode_16k;
        if (wide != 0 && addr[11]) return;  // odd register half in 16 KB mode
        pg   = addr[12:11];
        pair = pg | wide;
        vv   = v;
        if (cfg_shadow.sram_on) begin
            hit = ((vv & cfg_shadow.select_bit) != 0) &&
                  ((((vv ^ cfg_shadow.select_bit) << wide) & cfg_shadow.range_mask) == 0);
            page_sram[pg]   = hit;
            page_sram[pair] = hit;
            if (hit) begin
                page_base[pg]   = 16'((vv << (13 + wide)) & cfg_shadow.sram_amask);
                page_base[pair] = 16'(((vv << (13 + wide)) | (wide != 0 ? 32'h2000 : 32'h0))
                                      & cfg_shadow.sram_amask);
                page_wr[pg]     = (vv & cfg_shadow.protect_bit) == 0;
                page_wr[pair]   = (vv & cfg_shadow.protect_bit) == 0;
                return;
            end
        end
        rom = (vv << wide) & cfg_shadow.rom_mask;
        page_rom[pg]   = bsm_pkg::PAGE_W'(rom);
        page_rom[pair] = bsm_pkg::PAGE_W'(rom | wide);
    endfunction

    function automatic access_reply_t predict_access(input logic op, input logic [15:0] addr,
                                                     input logic [7:0] data);
        access_reply_t r;
        logic [1:0] pg;
        r = '0;
        r.in_window = (addr >= 16'h4000) && (addr < 16'hC000);
        pg = addr[14:13] - 2'd2;
        if (op == bsm_pkg::OP_WRITE) begin
            if (addr[15:13] == bsm_pkg::AREA_BANK) begin
                bank_select(addr, data);
            end else if (r.in_window && cfg_shadow.sram_on &&
                         (addr >= 16'h6000 || cfg_shadow.low_writes)) begin
                if (page_sram[pg] && page_wr[pg]) sram_image[sram_slot(pg, addr)] = data;
            end
        end else if (r.in_window) begin
            if (cfg_shadow.sram_on && page_sram[pg]) begin
                r.from_sram = 1'b1;
                r.read_data = sram_image[sram_slot(pg, addr)];
            end else begin
                r.rom_page   = page_rom[pg];
                r.rom_offset = addr[12:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR: %s", msg);
    endtask

    task automatic write_reg(input logic [bsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bsm_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        shadow_reg_write(idx, value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(input mapper_cfg_t s);
        write_reg(bsm_pkg::CFG_BANK_16K,     bsm_pkg::CFG_DATA_W'(s.mode_16k));
        write_reg(bsm_pkg::CFG_RANGE_MASK,   bsm_pkg::CFG_DATA_W'(s.range_mask));
        write_reg(bsm_pkg::CFG_ROM_MASK,     bsm_pkg::CFG_DATA_W'(s.rom_mask));
        write_reg(bsm_pkg::CFG_SRAM_ENABLE,  bsm_pkg::CFG_DATA_W'(s.sram_on));
        write_reg(bsm_pkg::CFG_SRAM_AMASK,   s.sram_amask);
        write_reg(bsm_pkg::CFG_SELECT_MASK,  bsm_pkg::CFG_DATA_W'(s.select_bit));
        write_reg(bsm_pkg::CFG_PROTECT_MASK, bsm_pkg::CFG_DATA_W'(s.protect_bit));
        write_reg(bsm_pkg::CFG_WRITE_LOW,    bsm_pkg::CFG_DATA_W'(s.low_writes));
    endtask

    // always waits on a clock edge before returning, so s_tvalid is never driven twice in a step
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_replies.size() != 0);
    endtask

    task automatic start_phase(input mapper_cfg_t s);
        pause_until_drained();
        apply_settings(s);
    endtask

    task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] data);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_replies.push_back(predict_access(op, addr, data));
    endtask

    function automatic mapper_cfg_t random_settings();
        mapper_cfg_t s;
        s.mode_16k   = 1'($urandom);
        s.range_mask = 9'($urandom);
        s.rom_mask   = 9'($urandom);
        s.sram_on    = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 5))
            0:       s.sram_amask = 16'h0000;
            1:       s.sram_amask = 16'h01FF;
            2:       s.sram_amask = 16'h1FFF;
            3:       s.sram_amask = 16'h7FFF;
            4:       s.sram_amask = 16'hFFFF;
            default: s.sram_amask = 16'($urandom);
        endcase
        s.select_bit  = ($urandom_range(0, 8) == 8) ? 8'h00 : 8'(1 << $urandom_range(0, 7));
        s.protect_bit = ($urandom_range(0, 8) == 8) ? 8'h00 : 8'(1 << $urandom_range(0, 7));
        s.low_writes  = 1'($urandom);
        return s;
    endfunction

    // mostly window reads and writes mixed with bank selects; a few raw words
    task automatic send_random_accesses(input int count);
        int unsigned kind;
        logic        op;
        logic [15:0] addr, win;
        logic [7:0]  data;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            data = 8'($urandom);
            win  = 16'($urandom_range(16'h4000, 16'hBFFF));
            // small offsets make reads land on bytes written earlier
            if ($urandom_range(0, 1)) win = (win & 16'hE000) | 16'($urandom_range(0, 31));
            if (kind < 25) begin
                op   = bsm_pkg::OP_WRITE;
                addr = 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
                if ($urandom_range(0, 1))
                    data = 8'(cfg_shadow.select_bit |
                              ($urandom & ~(cfg_shadow.range_mask >> cfg_shadow.mode_16k)));
            end else if (kind < 60) begin
                op   = bsm_pkg::OP_WRITE;
                addr = win;
            end else if (kind < 93) begin
                op   = bsm_pkg::OP_READ;
                addr = win;
            end else begin
                op   = 1'($urandom);
                addr = 16'($urandom);
            end
            send_access(op, addr, data);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_window_edges();
        // reset mapping: ROM bank 0 everywhere, no SRAM
        send_access(bsm_pkg::OP_READ,  16'h0000, 8'hFF);
        send_access(bsm_pkg::OP_READ,  16'h3FFF, 8'h00);
        send_access(bsm_pkg::OP_READ,  16'h4000, 8'h00);
        send_access(bsm_pkg::OP_READ,  16'h7FFF, 8'h00);
        send_access(bsm_pkg::OP_READ,  16'hBFFF, 8'h00);
        send_access(bsm_pkg::OP_READ,  16'hC000, 8'h00);
        send_access(bsm_pkg::OP_WRITE, 16'hFFFF, 8'hFF);
        send_access(bsm_pkg::OP_WRITE, 16'h4000, 8'h00);
    endtask

    task automatic test_rom_banking();
        pause_until_drained();
        write_reg(bsm_pkg::CFG_SELECT_MASK, 16'h0020);
        write_reg(bsm_pkg::CFG_ROM_MASK,    16'h01FF);
        send_access(bsm_pkg::OP_WRITE, 16'h6000, 8'hFF);
        send_access(bsm_pkg::OP_WRITE, 16'h6FFF, 8'h20);  // select bit without SRAM: ROM bank
        send_access(bsm_pkg::OP_READ,  16'h5FFF, 8'h00);
        send_access(bsm_pkg::OP_READ,  16'h6000, 8'h00);
    endtask

    task automatic test_sram_8k();
        pause_until_drained();
        write_reg(bsm_pkg::CFG_SRAM_ENABLE,  16'h0001);
        write_reg(bsm_pkg::CFG_SRAM_AMASK,   16'h1FFF);
        write_reg(bsm_pkg::CFG_RANGE_MASK,   16'h01C0);
        write_reg(bsm_pkg::CFG_PROTECT_MASK, 16'h0010);
        send_access(bsm_pkg::OP_WRITE, 16'h7000, 8'h21);
        send_access(bsm_pkg::OP_WRITE, 16'h8005, 8'hA5);
        send_access(bsm_pkg::OP_READ,  16'h8005, 8'h00);
        send_access(bsm_pkg::OP_WRITE, 16'h6000, 8'h30);  // protected SRAM
        send_access(bsm_pkg::OP_WRITE, 16'h4005, 8'h00);  // low write blocked
        send_access(bsm_pkg::OP_READ,  16'h4005, 8'h00);
        send_access(bsm_pkg::OP_WRITE, 16'h6800, 8'h60);  // range bit set: ROM
        send_access(bsm_pkg::OP_READ,  16'h6000, 8'h00);
    endtask

    task automatic test_sram_16k();
        pause_until_drained();
        write_reg(bsm_pkg::CFG_BANK_16K,     16'h0001);
        write_reg(bsm_pkg::CFG_SRAM_AMASK,   16'h3FFF);
        write_reg(bsm_pkg::CFG_SELECT_MASK,  16'h0010);
        write_reg(bsm_pkg::CFG_PROTECT_MASK, 16'h0080);
        write_reg(bsm_pkg::CFG_WRITE_LOW,    16'h0001);
        send_access(bsm_pkg::OP_WRITE, 16'h6800, 8'h10);  // odd half, ignored
        send_access(bsm_pkg::OP_WRITE, 16'h7800, 8'h05);  // odd half, ignored
        send_access(bsm_pkg::OP_WRITE, 16'h7000, 8'h10);  // both halves to SRAM, upper at +2000h
        send_access(bsm_pkg::OP_WRITE, 16'hA001, 8'h5A);
        send_access(bsm_pkg::OP_READ,  16'hA001, 8'h00);
        send_access(bsm_pkg::OP_WRITE, 16'h6000, 8'h03);
        send_access(bsm_pkg::OP_READ,  16'h6000, 8'h00);
    endtask

    task automatic test_config_extremes();
        start_phase('{1'b0, 9'h000, 9'h000, 1'b0, 16'h0000, 8'h00, 8'h00, 1'b0});
        send_random_accesses(120);
        start_phase('{1'b1, 9'h1FF, 9'h1FF, 1'b1, 16'hFFFF, 8'h80, 8'h80, 1'b1});
        send_random_accesses(120);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 4; p++) begin
            start_phase(random_settings());
            send_random_accesses(130);
        end
    endtask

    task automatic test_output_backpressure();
        start_phase(random_settings());
        hold_request = 300;
        send_random_accesses(130);
    endtask

    task automatic test_drain_pause();
        start_phase(random_settings());
        send_random_accesses(60);
        pause_until_drained();
        send_random_accesses(60);
    endtask

    task automatic test_full_rate();
        start_phase('{1'b0, 9'h1C0, 9'h0FF, 1'b1, 16'h1FFF, 8'h20, 8'h10, 1'b0});
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        send_random_accesses(150);
    endtask

    // ------------------------------------------------------------------
    // receiver, checker, watchdog
    // ------------------------------------------------------------------
    initial begin : receiver
        int n;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                n = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want)
            flag_error($sformatf("word %0d: %s is %0h, expected %0h",
                                 words_checked, name, got, want));
    endtask

    always @(posedge aclk) begin : result_check
        access_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                flag_error($sformatf("word %0d: result with nothing expected", words_checked));
            end else begin
                want = expected_replies.pop_front();
                check_field("in_window",  m_tuser[0],     want.in_window);
                check_field("from_sram",  m_tuser[1],     want.from_sram);
                check_field("read_data",  m_tdata[7:0],   want.read_data);
                check_field("rom_page",   m_tdata[16:8],  want.rom_page);
                check_field("rom_offset", m_tdata[29:17], want.rom_offset);
            end
            words_checked++;
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main
        int k;
        model_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_window_edges();
        test_rom_banking();
        test_sram_8k();
        test_sram_16k();
        test_config_extremes();
        test_random_settings();
        test_output_backpressure();
        test_drain_pause();
        test_full_rate();

        s_tvalid <= 1'b0;
        for (k = 0; k < 5000 && expected_replies.size() != 0; k++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_replies.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_replies.size()));

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/bsm_pkg.sv
src/bsm_ram.sv
src/bsm_ctrl.sv
src/bsm_dp.sv
src/bank_switch_mapper_with_sram_unit.sv
test/tb_top.sv
